[hdl/arx_model_filter_top_defines.svh]
// Assertion macros for the ARX model filter.
`ifndef ARX_MODEL_FILTER_TOP_DEFINES_SVH
`define ARX_MODEL_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ARX_MF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("arx_model_filter check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ARX_MF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arx_model_filter check failed");

`endif

[hdl/arx_mf_pkg.sv]
// Shared types, constants and codes of the ARX model filter.
`default_nettype none
package arx_mf_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int COEF_W      = 18;
	localparam int FRAC_W      = 14;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int ACC_W       = 46;
	localparam int YF_W        = ACC_W - FRAC_W;
	localparam int HIST_LEN    = 3;
	localparam int NUM_FF_TAPS = 3;
	localparam int NUM_FB_TAPS = 3;
	localparam int MAX_DELAY   = 16;
	localparam int PTR_W       = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int DLY_W       = $clog2(MAX_DELAY + 1);
	localparam int DLY_FIELD_W = 5;
	localparam int ADDR_W      = 5;
	localparam int TAP_W       = 3;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;

	// register indexes (word address)
	typedef enum logic [2:0] {
		REG_FF0   = 3'd0,
		REG_FF1   = 3'd1,
		REG_FF2   = 3'd2,
		REG_FB1   = 3'd3,
		REG_FB2   = 3'd4,
		REG_FB3   = 3'd5,
		REG_DELAY = 3'd6,
		REG_NONE  = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_M4,
		S_M5,
		S_FIN
	} state_t;

	// sequencer to datapath
	typedef struct packed {
		logic             start;
		logic             mul_en;
		logic [TAP_W-1:0] tap;
		logic             acc_en;
		logic             fin;
		logic             clr_ff;
		logic             clr_fb;
	} mac_ctrl_t;

	localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

endpackage
`default_nettype wire

[hdl/arx_mf_ram.sv]
// Generic simple dual-port RAM with registered, read-first output.
`default_nettype none
module arx_mf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/arx_mf_mac.sv]
// Shared multiply-accumulate datapath with tap histories, rounding and saturation.
`default_nettype none
module arx_mf_mac import arx_mf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire mac_ctrl_t ctrl,
	input  wire sample_t   delayed,
	input  wire sample_t   noise,
	input  wire coef_t     ff_coef [HIST_LEN],
	input  wire coef_t     fb_coef [HIST_LEN],
	output sample_t        y
);

	sample_t ih_q [HIST_LEN];
	sample_t oh_q [HIST_LEN];

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     sub_s1;

	coef_t                    mul_a;
	sample_t                  mul_b;
	logic                     mul_sub;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  sum;
	logic signed [YF_W-1:0]   y_full;
	logic [YF_W-SAMPLE_W:0]   y_hi;

	// operand select; taps past the configured order contribute nothing
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_sub = 1'b0;
		case (ctrl.tap)
			3'd0: begin
				mul_a = ff_coef[0];
				mul_b = delayed;
			end
			3'd1: begin
				mul_a = (NUM_FF_TAPS > 1) ? ff_coef[1] : '0;
				mul_b = ih_q[1];
			end
			3'd2: begin
				mul_a = (NUM_FF_TAPS > 2) ? ff_coef[2] : '0;
				mul_b = ih_q[2];
			end
			3'd3: begin
				mul_a   = fb_coef[0];
				mul_b   = oh_q[0];
				mul_sub = 1'b1;
			end
			3'd4: begin
				mul_a   = (NUM_FB_TAPS > 1) ? fb_coef[1] : '0;
				mul_b   = oh_q[1];
				mul_sub = 1'b1;
			end
			3'd5: begin
				mul_a   = (NUM_FB_TAPS > 2) ? fb_coef[2] : '0;
				mul_b   = oh_q[2];
				mul_sub = 1'b1;
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_sub = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= mul_a * mul_b;
			sub_s1  <= mul_sub;
		end
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign sum      = sub_s1 ? (acc_q - prod_ext) : (acc_q + prod_ext);

	// noise aligned to Q.14 with the half-LSB rounding bias folded in
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= {{(ACC_W-SAMPLE_W-FRAC_W){noise[SAMPLE_W-1]}}, noise,
				1'b1, {(FRAC_W-1){1'b0}}};
		end else if (ctrl.acc_en) begin
			acc_q <= sum;
		end
	end

	// floor shift, then clamp to the sample range
	assign y_full = sum[ACC_W-1:FRAC_W];
	assign y_hi   = y_full[YF_W-1:SAMPLE_W-1];

	always_comb begin
		if ((&y_hi) || !(|y_hi)) begin
			y = y_full[SAMPLE_W-1:0];
		end else if (y_full[YF_W-1]) begin
			y = SAT_MIN;
		end else begin
			y = SAT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				ih_q[i] <= '0;
				oh_q[i] <= '0;
			end
		end else begin
			if (ctrl.clr_ff) begin
				for (int i = 0; i < HIST_LEN; i++) begin
					ih_q[i] <= '0;
				end
			end else if (ctrl.mul_en && ctrl.tap == '0) begin
				ih_q[2] <= ih_q[1];
				ih_q[1] <= ih_q[0];
				ih_q[0] <= delayed;
			end
			if (ctrl.clr_fb) begin
				for (int i = 0; i < HIST_LEN; i++) begin
					oh_q[i] <= '0;
				end
			end else if (ctrl.fin) begin
				oh_q[2] <= oh_q[1];
				oh_q[1] <= oh_q[0];
				oh_q[0] <= y;
			end
		end
	end

endmodule
`default_nettype wire

[hdl/arx_model_filter_top.sv]
// Top level of the ARX model filter: register port, delay-line RAM, sequencer, output stage.
`default_nettype none
`include "arx_model_filter_top_defines.svh"
// Third-order ARX difference equation with a transport delay of 1 to 16 samples.
// Each transfer on the input channel carries one drive sample and one noise
// sample, and yields exactly one saturated model_output. The delay line lives
// in a 16-entry RAM with per-entry valid bits, so writing input_delay clears it
// at once with no clearing pass. In the engine, one item goes through the RAM
// read and write-back, then one step per tap, for all six taps, through the
// single shared 18x24 multiplier, and a last step to round and saturate. A
// one-item input buffer takes the next transfer while the engine runs, and the
// output register holds a result while the next item is computed; the engine
// waits in its final step only while that register is still full.
module arx_model_filter_top import arx_mf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sample_t           drive_sample,
	input  wire sample_t           noise_sample,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sample_t                model_output
);

	coef_t            ff_coef_q [HIST_LEN];
	coef_t            fb_coef_q [HIST_LEN];
	logic [DLY_W-1:0] delay_q;

	logic             cfg_wr;
	reg_idx_t         cfg_idx;
	logic [DLY_FIELD_W-1:0] dly_field;
	logic [DLY_W-1:0] dly_eff;

	logic             inbuf_valid_q;
	sample_t          drive_q;
	sample_t          noise_q;

	state_t           state_q, state_d;
	mac_ctrl_t        ctrl;
	logic             out_free;
	logic             fin_fire;

	logic [PTR_W-1:0]     ptr_q;
	logic [PTR_W-1:0]     rd_ptr;
	logic [DLY_W-1:0]     ptr_inc;
	logic [MAX_DELAY-1:0] vld_q;
	logic                 vld_rd_q;
	logic [SAMPLE_W-1:0]  ram_rdata;
	sample_t              delayed;
	logic                 rd_step;

	sample_t          y;
	sample_t          y_q;
	logic             out_valid_q;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	assign dly_field = pwdata[DLY_FIELD_W-1:0];
	always_comb begin
		if (dly_field == '0) begin
			dly_eff = DLY_W'(1);
		end else if (32'(dly_field) > MAX_DELAY) begin
			dly_eff = DLY_W'(MAX_DELAY);
		end else begin
			dly_eff = DLY_W'(dly_field);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				ff_coef_q[i] <= '0;
				fb_coef_q[i] <= '0;
			end
			delay_q <= DLY_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FF0:   ff_coef_q[0] <= pwdata[COEF_W-1:0];
				REG_FF1:   ff_coef_q[1] <= pwdata[COEF_W-1:0];
				REG_FF2:   ff_coef_q[2] <= pwdata[COEF_W-1:0];
				REG_FB1:   fb_coef_q[0] <= pwdata[COEF_W-1:0];
				REG_FB2:   fb_coef_q[1] <= pwdata[COEF_W-1:0];
				REG_FB3:   fb_coef_q[2] <= pwdata[COEF_W-1:0];
				REG_DELAY: delay_q      <= dly_eff;
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FF0:   prdata = {{(32-COEF_W){ff_coef_q[0][COEF_W-1]}}, ff_coef_q[0]};
			REG_FF1:   prdata = {{(32-COEF_W){ff_coef_q[1][COEF_W-1]}}, ff_coef_q[1]};
			REG_FF2:   prdata = {{(32-COEF_W){ff_coef_q[2][COEF_W-1]}}, ff_coef_q[2]};
			REG_FB1:   prdata = {{(32-COEF_W){fb_coef_q[0][COEF_W-1]}}, fb_coef_q[0]};
			REG_FB2:   prdata = {{(32-COEF_W){fb_coef_q[1][COEF_W-1]}}, fb_coef_q[1]};
			REG_FB3:   prdata = {{(32-COEF_W){fb_coef_q[2][COEF_W-1]}}, fb_coef_q[2]};
			REG_DELAY: prdata = 32'(delay_q);
			default:   prdata = '0;
		endcase
	end

	// input buffer: one item waits here while the engine runs
	assign in_ready = !inbuf_valid_q;
	assign rd_step  = (state_q == S_RD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inbuf_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			inbuf_valid_q <= 1'b1;
		end else if (rd_step) begin
			inbuf_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			drive_q <= drive_sample;
			noise_q <= noise_sample;
		end
	end

	// delay line: read the oldest slot and overwrite it in the same cycle
	assign rd_ptr  = (DLY_W'(ptr_q) >= delay_q) ? '0 : ptr_q;
	assign ptr_inc = DLY_W'(rd_ptr) + DLY_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			vld_q <= '0;
		end else if (cfg_wr && cfg_idx == REG_DELAY) begin
			ptr_q <= '0;
			vld_q <= '0;
		end else if (rd_step) begin
			ptr_q         <= (ptr_inc >= delay_q) ? '0 : ptr_inc[PTR_W-1:0];
			vld_q[rd_ptr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_step) begin
			vld_rd_q <= vld_q[rd_ptr];
		end
	end

	arx_mf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(MAX_DELAY)
	) u_delay_ram (
		.clk  (clk),
		.we   (rd_step),
		.waddr(rd_ptr),
		.wdata(drive_q),
		.re   (rd_step),
		.raddr(rd_ptr),
		.rdata(ram_rdata)
	);

	// a slot never written since reset or a delay change reads as zero
	assign delayed = vld_rd_q ? sample_t'(ram_rdata) : '0;

	// sequencer
	assign out_free = !out_valid_q || out_ready;
	assign fin_fire = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		ctrl.clr_ff = cfg_wr && (cfg_idx == REG_FF0 || cfg_idx == REG_FF1
			|| cfg_idx == REG_FF2);
		ctrl.clr_fb = cfg_wr && (cfg_idx == REG_FB1 || cfg_idx == REG_FB2
			|| cfg_idx == REG_FB3);
		case (state_q)
			S_IDLE: begin
				if (inbuf_valid_q) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				ctrl.start = 1'b1;
				state_d    = S_M0;
			end
			S_M0: begin
				ctrl.mul_en = 1'b1;
				ctrl.tap    = TAP_W'(0);
				state_d     = S_M1;
			end
			S_M1: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_en = 1'b1;
				ctrl.tap    = TAP_W'(1);
				state_d     = S_M2;
			end
			S_M2: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_en = 1'b1;
				ctrl.tap    = TAP_W'(2);
				state_d     = S_M3;
			end
			S_M3: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_en = 1'b1;
				ctrl.tap    = TAP_W'(3);
				state_d     = S_M4;
			end
			S_M4: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_en = 1'b1;
				ctrl.tap    = TAP_W'(4);
				state_d     = S_M5;
			end
			S_M5: begin
				ctrl.mul_en = 1'b1;
				ctrl.acc_en = 1'b1;
				ctrl.tap    = TAP_W'(5);
				state_d     = S_FIN;
			end
			S_FIN: begin
				// hold until the output register can take the result
				if (out_free) begin
					ctrl.fin = 1'b1;
					state_d  = inbuf_valid_q ? S_RD : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	arx_mf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.delayed(delayed),
		.noise  (noise_q),
		.ff_coef(ff_coef_q),
		.fb_coef(fb_coef_q),
		.y      (y)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			y_q <= y;
		end
	end

	assign out_valid    = out_valid_q;
	assign model_output = y_q;

	`ARX_MF_ASSERT_NOW(a_ptr_in_range, 1'b1, DLY_W'(ptr_q) < delay_q)
	`ARX_MF_ASSERT_NOW(a_start_has_item, state_q == S_RD, $past(inbuf_valid_q))
	`ARX_MF_ASSERT_NEXT(a_fin_fills_out, fin_fire, out_valid_q && model_output == $past(y))
	`ARX_MF_ASSERT_NEXT(a_delay_wr_rewinds, cfg_wr && cfg_idx == REG_DELAY, ptr_q == '0 && vld_q == '0)

endmodule
`default_nettype wire

[verif/arx_model_filter_checker.sv]
// Checker for the ARX model filter: follows register writes, predicts and compares outputs.
`timescale 1ns / 100ps
module arx_model_filter_checker import arx_mf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  sample_t           drive_sample,
	input  sample_t           noise_sample,
	input  logic              out_valid,
	input  logic              out_ready,
	input  sample_t           model_output,
	output int                mismatches,
	output int                awaited,
	output int                outputs_checked
);

	localparam int RING_LEN = 16;

	coef_t       ff_gain [HIST_LEN];
	coef_t       fb_gain [HIST_LEN];
	int unsigned lag;
	int unsigned lag_slot;
	sample_t     lag_line [MAX_DELAY];
	sample_t     past_in [HIST_LEN];
	sample_t     past_out [HIST_LEN];
	sample_t     exp_ring [RING_LEN];
	int          exp_rd;
	int          exp_count;
	sample_t     want_y;
	sample_t     next_y;
	int          fail_tally;
	int          check_tally;

	task automatic clear_model();
		foreach (ff_gain[i]) ff_gain[i] = '0;
		foreach (fb_gain[i]) fb_gain[i] = '0;
		foreach (lag_line[i]) lag_line[i] = '0;
		foreach (past_in[i]) past_in[i] = '0;
		foreach (past_out[i]) past_out[i] = '0;
		lag       = 1;
		lag_slot  = 0;
		exp_rd    = 0;
		exp_count = 0;
	endtask

	task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		reg_idx_t               idx;
		logic [DLY_FIELD_W-1:0] dly;
		idx = reg_idx_t'(addr[ADDR_W-1:2]);
		dly = data[DLY_FIELD_W-1:0];
		case (idx)
			REG_FF0, REG_FF1, REG_FF2: begin
				ff_gain[int'(idx) - int'(REG_FF0)] = data[COEF_W-1:0];
				foreach (past_in[i]) past_in[i] = '0;
			end
			REG_FB1, REG_FB2, REG_FB3: begin
				fb_gain[int'(idx) - int'(REG_FB1)] = data[COEF_W-1:0];
				foreach (past_out[i]) past_out[i] = '0;
			end
			REG_DELAY: begin
				// clamp zero up to one and large values down to the line length
				if (dly == 0)
					lag = 1;
				else if (dly > MAX_DELAY)
					lag = MAX_DELAY;
				else
					lag = dly;
				foreach (lag_line[i]) lag_line[i] = '0;
				lag_slot = 0;
			end
			default: ;
		endcase
	endtask

	task automatic advance_model(input sample_t u, input sample_t e, output sample_t y);
		longint  acc;
		sample_t delayed;
		if (lag_slot >= lag)
			lag_slot = 0;
		delayed = lag_line[lag_slot];
		lag_line[lag_slot] = u;
		lag_slot++;
		if (lag_slot >= lag)
			lag_slot = 0;

		for (int i = HIST_LEN - 1; i > 0; i--)
			past_in[i] = past_in[i-1];
		past_in[0] = delayed;

		acc = longint'(e) <<< FRAC_W;
		for (int i = 0; i < NUM_FF_TAPS; i++)
			acc += longint'(ff_gain[i]) * longint'(past_in[i]);
		for (int i = 0; i < NUM_FB_TAPS; i++)
			acc -= longint'(fb_gain[i]) * longint'(past_out[i]);

		// round half up, then floor
		acc += longint'(1) <<< (FRAC_W - 1);
		acc = acc >>> FRAC_W;
		if (acc > longint'(SAT_MAX))
			y = SAT_MAX;
		else if (acc < longint'(SAT_MIN))
			y = SAT_MIN;
		else
			y = sample_t'(acc);

		for (int i = HIST_LEN - 1; i > 0; i--)
			past_out[i] = past_out[i-1];
		past_out[0] = y;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			fail_tally      = 0;
			check_tally     = 0;
			mismatches      <= 0;
			awaited         <= 0;
			outputs_checked <= 0;
		end else begin
			if (psel && penable && pwrite && pready)
				apply_write(paddr, pwdata);

			if (out_valid && out_ready) begin
				if (exp_count == 0) begin
					fail_tally++;
					$display("%0t: model_output expected none, got %0d",
						$time, model_output);
				end else begin
					want_y    = exp_ring[exp_rd];
					exp_rd    = (exp_rd + 1) % RING_LEN;
					exp_count = exp_count - 1;
					check_tally++;
					if (model_output !== want_y) begin
						fail_tally++;
						$display("%0t: model_output expected %0d, got %0d",
							$time, want_y, model_output);
					end
				end
			end

			if (in_valid && in_ready) begin
				advance_model(drive_sample, noise_sample, next_y);
				if (exp_count >= RING_LEN) begin
					fail_tally++;
					$display("%0t: model_output expected at most %0d pending, got %0d",
						$time, RING_LEN, exp_count + 1);
				end else begin
					exp_ring[(exp_rd + exp_count) % RING_LEN] = next_y;
					exp_count = exp_count + 1;
				end
			end

			mismatches      <= fail_tally;
			awaited         <= exp_count;
			outputs_checked <= check_tally;
		end
	end

endmodule

[verif/tb_arx_model_filter_top.sv]
// Testbench top for the ARX model filter: clock, reset, register setup, sample traffic, verdict.
`timescale 1ns / 100ps
module tb_arx_model_filter_top import arx_mf_pkg::*;;

	localparam int     LIMIT_NS     = 1_000_000;
	localparam int     PHASES       = 10;
	localparam int     PHASE_ITEMS  = 55;
	localparam int     HOLD_CYCLES  = 300;
	localparam int     SETTLE       = 24;
	localparam int     DRAIN_CAP    = 4000;
	localparam coef_t  COEF_MAX     = 18'sh1FFFF;
	localparam coef_t  COEF_MIN     = 18'sh20000;
	localparam coef_t  COEF_ONE     = 18'sd16384;
	localparam coef_t  COEF_NEG_HALF = -18'sd8192;

	typedef enum int {MIX_STABLE, MIX_WILD, MIX_EXTREME} coef_mix_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [31:0]       pwdata       = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	sample_t           drive_sample = '0;
	sample_t           noise_sample = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	sample_t           model_output;

	int mismatches;
	int awaited;
	int outputs_checked;
	int tx_gap_max    = 0;
	int rx_gap_max    = 0;
	int rx_hold       = 0;
	int items_sent    = 0;
	int settings_used = 1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	arx_model_filter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.drive_sample (drive_sample),
		.noise_sample (noise_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.model_output (model_output)
	);

	arx_model_filter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.drive_sample    (drive_sample),
		.noise_sample    (noise_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.model_output    (model_output),
		.mismatches      (mismatches),
		.awaited         (awaited),
		.outputs_checked (outputs_checked)
	);

	function automatic sample_t draw_sample(input int small_pct);
		int      r;
		sample_t s;
		r = $urandom_range(0, 99);
		if (r < small_pct)
			s = sample_t'(int'($urandom_range(0, 65536)) - 32768);
		else if (r < small_pct + 8) begin
			case ($urandom_range(0, 3))
				0:       s = SAT_MAX;
				1:       s = SAT_MIN;
				2:       s = '0;
				default: s = '1;
			endcase
		end else
			s = sample_t'($urandom);
		return s;
	endfunction

	function automatic coef_t draw_coef(input coef_mix_t mix, input int span);
		coef_t c;
		case (mix)
			MIX_STABLE: c = coef_t'(int'($urandom_range(0, 2 * span)) - span);
			MIX_WILD:   c = coef_t'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0:       c = COEF_MAX;
					1:       c = COEF_MIN;
					2:       c = COEF_ONE;
					default: c = '1;
				endcase
			end
		endcase
		return c;
	endfunction

	// junk in the unused upper bits
	function automatic logic [31:0] coef_word(input coef_t c);
		logic [31:0] w;
		w = $urandom;
		w[COEF_W-1:0] = c;
		return w;
	endfunction

	function automatic logic [31:0] delay_word(input int code);
		logic [31:0] w;
		w = $urandom;
		w[DLY_FIELD_W-1:0] = code[DLY_FIELD_W-1:0];
		return w;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	task automatic release_bus();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic load_random_setting(input int delay_code);
		coef_mix_t mix;
		int        r;
		r = $urandom_range(0, 5);
		mix = (r < 3) ? MIX_STABLE : (r < 5) ? MIX_WILD : MIX_EXTREME;
		write_reg(REG_FF0, coef_word(draw_coef(mix, 1 << 15)));
		write_reg(REG_FF1, coef_word(draw_coef(mix, 1 << 15)));
		write_reg(REG_FF2, coef_word(draw_coef(mix, 1 << 15)));
		write_reg(REG_FB1, coef_word(draw_coef(mix, 1 << 12)));
		write_reg(REG_FB2, coef_word(draw_coef(mix, 1 << 12)));
		write_reg(REG_FB3, coef_word(draw_coef(mix, 1 << 12)));
		write_reg(REG_DELAY, delay_word(delay_code));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_NONE, $urandom);
		release_bus();
	endtask

	task automatic send_item(input sample_t u, input sample_t e);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		drive_sample <= u;
		noise_sample <= e;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// wait until every predicted output has been transferred, then let the engine settle
	task automatic drain_results();
		int waited;
		waited = 0;
		@(posedge clk);
		while (awaited != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : result_sink
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int delay_code;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: output is the noise sample alone
		send_item(SAT_MAX, SAT_MAX);
		send_item(SAT_MIN, SAT_MIN);
		send_item('0, '1);
		send_item('1, sample_t'(1));
		in_valid <= 1'b0;
		drain_results();

		// delay code zero (clamped to one), extreme feed-forward gains, saturation both ways
		tx_gap_max = 15;
		rx_gap_max = 15;
		write_reg(REG_FF0, coef_word(COEF_MAX));
		write_reg(REG_FF1, coef_word(COEF_MIN));
		write_reg(REG_FF2, coef_word(COEF_ONE));
		write_reg(REG_FB1, coef_word(COEF_NEG_HALF));
		write_reg(REG_FB2, coef_word('0));
		write_reg(REG_FB3, coef_word('0));
		write_reg(REG_DELAY, delay_word(0));
		write_reg(REG_NONE, $urandom);
		release_bus();
		send_item(SAT_MAX, '0);
		send_item(SAT_MAX, '0);
		send_item(SAT_MIN, '0);
		send_item(SAT_MIN, SAT_MIN);
		send_item(SAT_MAX, SAT_MAX);
		send_item('0, '0);
		send_item(sample_t'(1), '0);
		send_item('1, '0);
		in_valid <= 1'b0;
		drain_results();

		// delay above the line length, extreme feedback
		tx_gap_max = 4;
		rx_gap_max = 0;
		write_reg(REG_FF0, coef_word(COEF_ONE));
		write_reg(REG_FF1, coef_word('1));
		write_reg(REG_FF2, coef_word(COEF_MAX));
		write_reg(REG_FB1, coef_word(COEF_MAX));
		write_reg(REG_FB2, coef_word(COEF_MIN));
		write_reg(REG_FB3, coef_word('1));
		write_reg(REG_DELAY, delay_word(17));
		release_bus();
		repeat (12) send_item(draw_sample(20), draw_sample(50));
		in_valid <= 1'b0;
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			delay_code = (ph == 0) ? MAX_DELAY : (ph == PHASES - 1) ? 31 :
				$urandom_range(0, 31);
			load_random_setting(delay_code);
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			if (ph == PHASES / 2) begin
				// back up the output and keep offering input
				tx_gap_max = 0;
				rx_hold    = HOLD_CYCLES;
			end
			repeat (PHASE_ITEMS) send_item(draw_sample(40), draw_sample(80));
			in_valid <= 1'b0;
			drain_results();
		end

		$display("Filter run: %0d sample transfers, %0d register settings, %0d outputs compared.",
			items_sent, settings_used, outputs_checked);
		$display("Included delays 0/16/17/31, saturation both ways, a %0d-cycle stall.",
			HOLD_CYCLES);
		if (mismatches == 0 && awaited == 0)
			$display("tb_arx_model_filter_top OK");
		else
			$display("tb_arx_model_filter_top NOT OK");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("Timeout: run did not complete in time");
		$display("tb_arx_model_filter_top NOT OK");
		$finish;
	end

endmodule
